FILE: rtl/hcc_pkg.sv
// Shared types and constants for the Hamiltonian cycle counter.
package hcc_pkg;

  localparam int VC_W  = 5;
  localparam int IDX_W = 4;
  localparam int ROW_W = 16;
  localparam int CNT_W = 41;
  localparam int OUT_W = 40;

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  typedef enum logic {
    ALU_EXTEND,
    ALU_CLOSE
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [CNT_W-1:0]   rdata;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   step;
  } alu_in_t;

endpackage

FILE: rtl/hcc_ram.sv
// Generic simple dual-port RAM with registered read.
module hcc_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 491520,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hcc_pick.sv
// Lowest-set-bit picker: index of the lowest set bit and the mask without it.
module hcc_pick #(
  parameter int W   = 15,
  localparam int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  mask,
  output logic [IW-1:0] idx,
  output logic [W-1:0]  rest
);

  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign rest = mask & (mask - W'(1));

endmodule

FILE: rtl/hcc_alu.sv
// Shared 41-bit adder for path extension and closing sums.
module hcc_alu import hcc_pkg::*; (
  input  alu_in_t          req,
  output logic [CNT_W-1:0] sum
);

  always_comb begin
    case (req.op)
      ALU_CLOSE: begin
        sum = req.total + req.rdata;
      end
      default: begin
        sum = req.rdata + req.step;
      end
    endcase
  end

endmodule

FILE: rtl/hamiltonian_cycle_counter_core.sv
// Top level of the Hamiltonian cycle counter: row store, sequencer and path table.
//
// Adjacency rows load one word per cycle while idle. A word with last_row set
// starts the count of Hamiltonian cycles through vertex 0 over the first
// vertex_count vertices; the block is not ready until the count word is loaded
// into the output register. The count walks every subset s of the other m = n-1
// vertices in increasing order through one path-count RAM port pair and one
// shared adder: each end vertex in s is read (S_ERD) and its count taken (S_EGOT);
// when the count is non-zero and it has free neighbours, the first target is read
// (S_FRD) and each extension writes back while reading the next (S_FWR). A count
// also seeds one entry per neighbour of vertex 0 (S_SEED) after S_START, and waits
// in S_FIN while the output register is still full. Entries are cleared as they
// are read, so the table is left zero for the next count. After reset a clearing
// pass zeroes (2^(MAX_VERTICES-1))*(MAX_VERTICES-1) entries (491520 at the default)
// before the first word is taken; configuration writes are taken at any time.
module hamiltonian_cycle_counter_core import hcc_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VC_W-1:0]  cfg_vertex_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_neighbor_bits,
  input  logic             in_last_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_cycle_count
);

  localparam int E     = MAX_VERTICES - 1;
  localparam int DEPTH = (1 << E) * E;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(E);
  localparam int RW    = $clog2(MAX_VERTICES);
  localparam int EP    = E + 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_START = 9'b000000100,
    S_SEED  = 9'b000001000,
    S_ERD   = 9'b000010000,
    S_EGOT  = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FWR   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [VC_W-1:0]  vertex_count_r;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_cycle_count_r, out_cycle_count_nxt;

  logic [ROW_W-1:0] rows_r [MAX_VERTICES];

  logic [E-1:0]     s_r, s_nxt;
  logic [E-1:0]     full_r, full_nxt;
  logic [E-1:0]     row0_r, row0_nxt;
  logic [E-1:0]     emask_r, emask_nxt;
  logic [E-1:0]     fmask_r, fmask_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [EW-1:0]    e_r, e_nxt;
  logic [CNT_W-1:0] c_r, c_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  logic [EW-1:0]    e_idx, f_idx;
  logic [E-1:0]     e_rest, f_rest;
  logic [AW-1:0]    seed_addr, tgt_addr;

  logic [VC_W-1:0]  n_c, m_c;
  logic [EP-1:0]    one_sh;
  logic [E-1:0]     full_c;
  logic [MAX_VERTICES-1:0] row0_x, rowe_x;
  logic [E-1:0]     adj_e, free_c;

  alu_in_t          alu_req;
  logic [CNT_W-1:0] alu_sum;

  logic             in_acc, go_next;

  hcc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_paths (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hcc_pick #(.W(E)) u_pick_e (
    .mask (emask_r),
    .idx  (e_idx),
    .rest (e_rest)
  );

  hcc_pick #(.W(E)) u_pick_f (
    .mask (fmask_r),
    .idx  (f_idx),
    .rest (f_rest)
  );

  hcc_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_cycle_count = out_cycle_count_r;

  // vertex count saturated to 1..MAX_VERTICES, full set of the m other vertices
  always_comb begin
    if (vertex_count_r == '0) begin
      n_c = VC_W'(1);
    end else if (32'(vertex_count_r) > MAX_VERTICES) begin
      n_c = VC_W'(MAX_VERTICES);
    end else begin
      n_c = vertex_count_r;
    end
    m_c    = n_c - VC_W'(1);
    one_sh = EP'(1) << m_c;
    full_c = E'(one_sh - EP'(1));
  end

  assign row0_x = MAX_VERTICES'(rows_r[0]);
  assign rowe_x = MAX_VERTICES'(rows_r[RW'(e_r) + RW'(1)]);
  assign adj_e  = rowe_x[MAX_VERTICES-1:1];
  assign free_c = adj_e & ~s_r & full_r;

  assign seed_addr = (AW'(E) << e_idx) + AW'(e_idx);
  assign tgt_addr  = base_r + (AW'(E) << f_idx) + AW'(f_idx);

  always_comb begin
    state_nxt           = state_r;
    clr_nxt             = clr_r;
    out_valid_nxt       = out_valid_r;
    out_cycle_count_nxt = out_cycle_count_r;
    s_nxt               = s_r;
    full_nxt            = full_r;
    row0_nxt            = row0_r;
    emask_nxt           = emask_r;
    fmask_nxt           = fmask_r;
    base_nxt            = base_r;
    tgt_nxt             = tgt_r;
    e_nxt               = e_r;
    c_nxt               = c_r;
    total_nxt           = total_r;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    ram_wdata           = '0;
    ram_raddr           = '0;
    go_next             = 1'b0;
    alu_req.op          = ALU_EXTEND;
    alu_req.rdata       = ram_rdata;
    alu_req.total       = total_r;
    alu_req.step        = c_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_last_row) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        full_nxt  = full_c;
        row0_nxt  = row0_x[MAX_VERTICES-1:1] & full_c;
        emask_nxt = row0_x[MAX_VERTICES-1:1] & full_c;
        total_nxt = '0;
        state_nxt = S_SEED;
      end
      S_SEED: begin
        if (emask_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = seed_addr;
          ram_wdata = CNT_W'(1);
          emask_nxt = e_rest;
        end else if (full_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          s_nxt     = E'(1);
          base_nxt  = AW'(E);
          emask_nxt = E'(1);
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        ram_raddr = base_r + AW'(e_idx);
        e_nxt     = e_idx;
        emask_nxt = e_rest;
        state_nxt = S_EGOT;
      end
      S_EGOT: begin
        // take the count and clear its entry
        c_nxt     = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = base_r + AW'(e_r);
        alu_req.op = ALU_CLOSE;
        if (ram_rdata != '0 && s_r == full_r && row0_r[e_r]) begin
          total_nxt = alu_sum;
        end
        if (ram_rdata != '0 && free_c != '0) begin
          fmask_nxt = free_c;
          state_nxt = S_FRD;
        end else begin
          go_next = 1'b1;
        end
      end
      S_FRD: begin
        ram_raddr = tgt_addr;
        tgt_nxt   = tgt_addr;
        fmask_nxt = f_rest;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        // write back this target, read the next one alongside
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = alu_sum;
        if (fmask_r != '0) begin
          ram_raddr = tgt_addr;
          tgt_nxt   = tgt_addr;
          fmask_nxt = f_rest;
        end else begin
          go_next = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_cycle_count_nxt = total_r[CNT_W-1:1];
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (go_next) begin
      if (emask_r != '0) begin
        state_nxt = S_ERD;
      end else if (s_r == full_r) begin
        state_nxt = S_FIN;
      end else begin
        s_nxt     = s_r + E'(1);
        base_nxt  = base_r + AW'(E);
        emask_nxt = s_r + E'(1);
        state_nxt = S_ERD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= VC_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vertex_count_r <= cfg_vertex_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (32'(in_row_index) < MAX_VERTICES)) begin
      rows_r[RW'(in_row_index)] <= in_neighbor_bits;
    end
    out_cycle_count_r <= out_cycle_count_nxt;
    s_r               <= s_nxt;
    full_r            <= full_nxt;
    row0_r            <= row0_nxt;
    emask_r           <= emask_nxt;
    fmask_r           <= fmask_nxt;
    base_r            <= base_nxt;
    tgt_r             <= tgt_nxt;
    e_r               <= e_nxt;
    c_r               <= c_nxt;
    total_r           <= total_nxt;
  end

  a_ext_outside_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWR) |-> ((fmask_r & s_r) == '0))
    else $error("extension target already in visited set");

  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD) |-> (emask_r != '0 && (s_r & ~full_r) == '0))
    else $error("subset walk left the vertex range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside finish");

  a_waddr_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < DEPTH))
    else $error("path table write beyond depth");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_row) |=> (state_r == S_START))
    else $error("last row did not start a count");

endmodule
